// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ERPR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ERPR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/erpr_pkg.sv =====
// types, constants and crc helper for the exception reply responder
`default_nettype none

package erpr_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLAVE_ADDRESS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LISTEN_SECOND     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESPONDER_ENABLED = 2'd2;

   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [15:0] CRC_LSB        = 16'h0001;
   localparam logic [7:0]  FUNC_ERROR_BIT = 8'h80;
   localparam logic [7:0]  EXC_CODE       = 8'h04;

   localparam int unsigned REPLY_IDX_W = 3;
   localparam logic [REPLY_IDX_W-1:0] REPLY_ADDR   = 3'd0;
   localparam logic [REPLY_IDX_W-1:0] REPLY_FUNC   = 3'd1;
   localparam logic [REPLY_IDX_W-1:0] REPLY_CODE   = 3'd2;
   localparam logic [REPLY_IDX_W-1:0] REPLY_CRC_LO = 3'd3;
   localparam logic [REPLY_IDX_W-1:0] REPLY_CRC_HI = 3'd4;

   typedef struct packed {
      logic [7:0] slave_address;
      logic       listen_on_second_port;
      logic       responder_enabled;
   } erpr_cfg_type;

   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] func;
      logic       flag_first;
      logic       flag_second;
   } erpr_job_type;

   // one byte through the reflected crc-16, bit at a time
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_LSB) != 16'h0000) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/erpr_if.sv =====
// valid/ready channel interfaces for request bytes and reply bytes
`default_nettype none

interface erpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       chunk_end;

   modport source (output valid, output rx_byte, output chunk_end, input ready);
   modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface erpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_final;
   logic       link_ok_first;
   logic       link_ok_second;

   modport source (output valid, output tx_byte, output tx_final,
                   output link_ok_first, output link_ok_second, input ready);
   modport sink   (input valid, input tx_byte, input tx_final,
                   input link_ok_first, input link_ok_second, output ready);
endinterface

`default_nettype wire

// ===== rtl/exception_reply_responder.sv =====
// Exception reply responder, top level.
// req_chan carries received serial bytes (rx_byte) with chunk_end on the last
// byte of each receive chunk; rsp_chan carries reply bytes (tx_byte) with
// tx_final on the last byte and the sticky link_ok_first / link_ok_second flags.
// The csr port (csr_we, csr_index, csr_wdata) writes slave address, listen
// direction and enable; write only while idle.
// A chunk of at least MIN_FRAME_BYTES bytes that starts with the slave address
// yields a five byte exception reply: address, function | 0x80, code 4, crc lo/hi.
// Throughput: one request byte per cycle while the reply queue has room;
// QUEUE_DEPTH replies can wait. The reply sender loads one job at a time and
// sends its five bytes through a byte-per-cycle crc unit.
// A job passes the queue and the sender's job register before its first reply
// byte is registered onto rsp_chan; the rest follow one per cycle when not stalled.
// Reset clears counters, flags and the queue and restores register defaults.
// A stalled receiver holds the current reply byte; the queue then fills and
// req_chan.ready drops.
`default_nettype none

module exception_reply_responder
   import erpr_pkg::*;
#(
   parameter int unsigned MIN_FRAME_BYTES = 4,
   parameter int unsigned QUEUE_DEPTH     = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   erpr_req_if.sink                    req_chan,
   erpr_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   erpr_cfg_type cfg_ff, cfg_in;
   logic         push_valid;
   logic         push_ready;
   erpr_job_type push_job;
   logic         pop_valid;
   erpr_job_type pop_job;
   logic         pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLAVE_ADDRESS:     cfg_in.slave_address         = csr_wdata;
            CSR_LISTEN_SECOND:     cfg_in.listen_on_second_port = csr_wdata[0];
            CSR_RESPONDER_ENABLED: cfg_in.responder_enabled     = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address         <= 8'h00;
         cfg_ff.listen_on_second_port <= 1'b1;
         cfg_ff.responder_enabled     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   erpr_front #(
      .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   erpr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop        (pop)
   );

   erpr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job       (pop_job),
      .job_pop   (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== rtl/erpr_front.sv =====
// front end: counts chunk bytes, checks the address and queues reply jobs
`default_nettype none
`include "assert_macros.svh"

module erpr_front
   import erpr_pkg::*;
#(
   parameter int unsigned MIN_FRAME_BYTES = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire erpr_cfg_type cfg,
   erpr_req_if.sink          req_chan,
   input  wire logic         push_ready,
   output logic              push_valid,
   output erpr_job_type      push_job
);

   localparam logic [2:0] MIN_COUNT = 3'(MIN_FRAME_BYTES);

   logic [2:0] count_ff, count_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic       flag_first_ff, flag_first_in;
   logic       flag_second_ff, flag_second_in;
   logic       accept;
   logic [2:0] count_next;
   logic       frame_ok;

   assign req_chan.ready = push_ready;
   assign accept = req_chan.valid && push_ready;

   always_comb begin
      count_in       = count_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      flag_first_in  = flag_first_ff;
      flag_second_in = flag_second_ff;
      count_next     = count_ff;
      frame_ok       = 1'b0;
      if (accept) begin
         if (!cfg.responder_enabled) begin
            count_in = 3'd0;
         end else begin
            if (count_ff == 3'd0) begin
               first_in = req_chan.rx_byte;
            end else if (count_ff == 3'd1) begin
               second_in = req_chan.rx_byte;
            end
            if (count_ff < MIN_COUNT) begin
               count_next = count_ff + 3'd1;
            end
            count_in = count_next;
            if (req_chan.chunk_end) begin
               count_in = 3'd0;
               frame_ok = (count_next >= MIN_COUNT) && (first_in == cfg.slave_address);
               if (frame_ok) begin
                  if (cfg.listen_on_second_port) begin
                     flag_first_in = 1'b1;
                  end else begin
                     flag_second_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   assign push_valid           = frame_ok;
   assign push_job.addr        = first_in;
   assign push_job.func        = second_in | FUNC_ERROR_BIT;
   assign push_job.flag_first  = flag_first_in;
   assign push_job.flag_second = flag_second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= 3'd0;
         first_ff       <= 8'h00;
         second_ff      <= 8'h00;
         flag_first_ff  <= 1'b0;
         flag_second_ff <= 1'b0;
      end else begin
         count_ff       <= count_in;
         first_ff       <= first_in;
         second_ff      <= second_in;
         flag_first_ff  <= flag_first_in;
         flag_second_ff <= flag_second_in;
      end
   end

   `ERPR_ASSERT_NXT(a_flags_sticky, clock, reset, flag_first_ff && flag_second_ff,
      flag_first_ff && flag_second_ff, "link flags must stay set")
   `ERPR_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= MIN_COUNT,
      "chunk count above saturation")

endmodule

`default_nettype wire

// ===== rtl/erpr_queue.sv =====
// short job queue between the front and back ends
`default_nettype none
`include "assert_macros.svh"

module erpr_queue
   import erpr_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   input  wire erpr_job_type push_job,
   output logic              push_ready,
   output logic              pop_valid,
   output erpr_job_type      pop_job,
   input  wire logic         pop
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   erpr_job_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `ERPR_ASSERT_IMP(a_count_ptrs, clock, reset, count_ff == '0,
      wr_ptr_ff == rd_ptr_ff, "empty queue with pointers apart")

endmodule

`default_nettype wire

// ===== rtl/erpr_back.sv =====
// back end: sends the five reply bytes of each job, crc one byte per cycle
`default_nettype none
`include "assert_macros.svh"

module erpr_back
   import erpr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         job_valid,
   input  wire erpr_job_type job,
   output logic              job_pop,
   erpr_rsp_if.source        rsp_chan
);

   logic                   active_ff, active_in;
   logic [REPLY_IDX_W-1:0] idx_ff, idx_in;
   erpr_job_type           job_ff, job_in;
   logic [15:0]            crc_ff, crc_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             tx_byte_ff, tx_byte_in;
   logic                   tx_final_ff, tx_final_in;
   logic                   ok_first_ff, ok_first_in;
   logic                   ok_second_ff, ok_second_in;
   logic                   out_free;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign job_pop  = !active_ff && job_valid;

   always_comb begin
      active_in    = active_ff;
      idx_in       = idx_ff;
      job_in       = job_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      tx_byte_in   = tx_byte_ff;
      tx_final_in  = tx_final_ff;
      ok_first_in  = ok_first_ff;
      ok_second_in = ok_second_ff;
      if (job_pop) begin
         active_in = 1'b1;
         idx_in    = REPLY_ADDR;
         job_in    = job;
         crc_in    = CRC_INIT;
      end else if (active_ff && out_free) begin
         rsp_valid_in = 1'b1;
         tx_final_in  = 1'b0;
         ok_first_in  = job_ff.flag_first;
         ok_second_in = job_ff.flag_second;
         idx_in       = idx_ff + 1'b1;
         unique case (idx_ff)
            REPLY_ADDR: begin
               tx_byte_in = job_ff.addr;
               crc_in     = crc_feed(crc_ff, job_ff.addr);
            end
            REPLY_FUNC: begin
               tx_byte_in = job_ff.func;
               crc_in     = crc_feed(crc_ff, job_ff.func);
            end
            REPLY_CODE: begin
               tx_byte_in = EXC_CODE;
               crc_in     = crc_feed(crc_ff, EXC_CODE);
            end
            REPLY_CRC_LO: begin
               tx_byte_in = crc_ff[7:0];
            end
            REPLY_CRC_HI: begin
               tx_byte_in  = crc_ff[15:8];
               tx_final_in = 1'b1;
               active_in   = 1'b0;
            end
            default: begin
               active_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= REPLY_ADDR;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      crc_ff       <= crc_in;
      tx_byte_ff   <= tx_byte_in;
      tx_final_ff  <= tx_final_in;
      ok_first_ff  <= ok_first_in;
      ok_second_ff <= ok_second_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.tx_byte        = tx_byte_ff;
   assign rsp_chan.tx_final       = tx_final_ff;
   assign rsp_chan.link_ok_first  = ok_first_ff;
   assign rsp_chan.link_ok_second = ok_second_ff;

   `ERPR_ASSERT_IMP(a_idx_range, clock, reset, active_ff, idx_ff <= REPLY_CRC_HI,
      "reply index out of range")
   `ERPR_ASSERT_NXT(a_final_ends_job, clock, reset,
      active_ff && out_free && (idx_ff == REPLY_CRC_HI),
      rsp_valid_ff && tx_final_ff && !active_ff, "last reply byte must end the job")

endmodule

`default_nettype wire

// ===== sim/exception_reply_responder_test.sv =====
// testbench for the exception reply responder: directed table, then random chunks
module exception_reply_responder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import erpr_pkg::*;

   localparam int FRAME_MIN     = 4;
   localparam int REPLY_LEN     = 5;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_TARGET = 310;
   localparam int QUIET_TAIL    = 60;
   localparam int LONG_HOLD     = 90;
   localparam int HOLD_PHASE    = 2;
   localparam int REPORT_MAX    = 10;
   localparam logic [2:0] ANY_COUNT = 3'd7;

   typedef enum logic {ROW_BYTE, ROW_REG} row_kind_type;
   typedef enum int {CHUNK_GOOD, CHUNK_SHORT, CHUNK_FOREIGN, CHUNK_NOISE} chunk_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [7:0]             data;
      logic                   last;
      logic [2:0]             replies;
      logic [7:0]             func;
   } script_row_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_final;
      logic       link_first;
      logic       link_second;
   } reply_byte_type;

   // replies holds the reply byte count the row must cause, func the second reply byte
   script_row_type script [0:32] = '{
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h00, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h80, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h04, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h00, 1'b1, 3'd0, 8'h00},
      '{ROW_REG,  CSR_RESPONDER_ENABLED, 8'h01, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h00, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h7F, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'hFF, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h00, 1'b1, 3'd5, 8'hFF},
      '{ROW_REG,  CSR_LISTEN_SECOND,     8'h00, 1'b0, 3'd0, 8'h00},
      '{ROW_REG,  CSR_SLAVE_ADDRESS,     8'hFF, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'hFF, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'hFF, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h00, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'hFF, 1'b1, 3'd5, 8'hFF},
      // short chunk
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'hFF, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h01, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'hFF, 1'b1, 3'd0, 8'h00},
      // foreign address
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'hFE, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h03, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h00, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h00, 1'b1, 3'd0, 8'h00},
      // long chunk, count saturates and later bytes are not kept
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'hFF, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h00, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'hAA, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h55, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'hAA, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'h55, 1'b1, 3'd5, 8'h80},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'hFF, 1'b1, 3'd0, 8'h00},
      '{ROW_REG,  CSR_RESPONDER_ENABLED, 8'h00, 1'b0, 3'd0, 8'h00},
      '{ROW_BYTE, CSR_SLAVE_ADDRESS,     8'hFF, 1'b1, 3'd0, 8'h00},
      '{ROW_REG,  CSR_LISTEN_SECOND,     8'h01, 1'b0, 3'd0, 8'h00},
      '{ROW_REG,  CSR_RESPONDER_ENABLED, 8'h01, 1'b0, 3'd0, 8'h00}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   erpr_req_if req_if ();
   erpr_rsp_if rsp_if ();

   exception_reply_responder #(.MIN_FRAME_BYTES(FRAME_MIN)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // mirror of the block's registers and chunk state
   erpr_cfg_type model_cfg;
   logic [2:0]   chunk_bytes;
   logic [7:0]   held_addr;
   logic [7:0]   held_func;
   logic         link_first;
   logic         link_second;
   logic [7:0]   last_func_byte;

   reply_byte_type reply_bytes_due [$];
   reply_byte_type got_reply;
   reply_byte_type want_reply;

   logic quiet         = 1'b0;
   logic chunk_closed  = 1'b1;
   int   hold_request  = 0;
   int   fail_count    = 0;
   int   cycle_count   = 0;
   int   bytes_sent    = 0;
   int   bytes_enabled = 0;
   int   phase_bytes   = 0;
   int   replies_due   = 0;
   int   replies_seen  = 0;
   int   reg_writes    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void log_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
   endfunction

   // crc-16/modbus over address, function and code, fed bit by bit lsb first
   function automatic logic [15:0] modbus_crc(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2);
      logic [15:0] crc;
      logic [23:0] stream;
      crc = CRC_INIT;
      stream = {b2, b1, b0};
      for (int i = 0; i < 24; i++) begin
         if (crc[0] ^ stream[i]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

   // updates the chunk state for one accepted byte, queues any reply, returns its length
   function automatic int expect_reply_for(input logic [7:0] value, input logic last);
      logic [7:0]  frame [REPLY_LEN];
      logic [15:0] crc;
      logic        accepted;
      if (!model_cfg.responder_enabled) begin
         chunk_bytes = '0;
         return 0;
      end
      if (chunk_bytes == 0) begin
         held_addr = value;
      end else if (chunk_bytes == 1) begin
         held_func = value;
      end
      if (chunk_bytes < FRAME_MIN) begin
         chunk_bytes++;
      end
      if (!last) begin
         return 0;
      end
      accepted = (chunk_bytes >= FRAME_MIN) && (held_addr == model_cfg.slave_address);
      chunk_bytes = '0;
      if (!accepted) begin
         return 0;
      end
      if (model_cfg.listen_on_second_port) begin
         link_first = 1'b1;
      end else begin
         link_second = 1'b1;
      end
      frame[0] = held_addr;
      frame[1] = held_func | FUNC_ERROR_BIT;
      frame[2] = EXC_CODE;
      crc = modbus_crc(frame[0], frame[1], frame[2]);
      frame[3] = crc[7:0];
      frame[4] = crc[15:8];
      last_func_byte = frame[1];
      for (int k = 0; k < REPLY_LEN; k++) begin
         reply_bytes_due.push_back(reply_byte_type'{frame[k], k == REPLY_LEN - 1,
                                                    link_first, link_second});
      end
      replies_due++;
      return REPLY_LEN;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_SLAVE_ADDRESS:     model_cfg.slave_address = value;
         CSR_LISTEN_SECOND:     model_cfg.listen_on_second_port = value[0];
         CSR_RESPONDER_ENABLED: model_cfg.responder_enabled = value[0];
         default: ;
      endcase
      reg_writes++;
      @(posedge clock);
   endtask

   // offers one byte, returns at the edge of its transfer
   task automatic send_byte(input logic [7:0] value, input logic last, output int produced);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.rx_byte   <= value;
      req_if.chunk_end <= last;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      bytes_sent++;
      phase_bytes++;
      if (model_cfg.responder_enabled) begin
         bytes_enabled++;
      end
      chunk_closed = last;
      produced = expect_reply_for(value, last);
   endtask

   task automatic send_chunk(input chunk_kind_type kind);
      int         len;
      int         produced;
      logic [7:0] value;
      case (kind)
         CHUNK_SHORT: len = $urandom_range(1, FRAME_MIN - 1);
         CHUNK_NOISE: len = $urandom_range(1, 6);
         default:     len = ($urandom_range(0, 2) == 0) ? FRAME_MIN
                                                        : $urandom_range(FRAME_MIN, 9);
      endcase
      for (int k = 0; k < len; k++) begin
         value = 8'($urandom);
         if (k == 0 && kind != CHUNK_NOISE) begin
            value = model_cfg.slave_address;
            if (kind == CHUNK_FOREIGN) begin
               value ^= 8'($urandom_range(1, 255));
            end
         end
         if (kind == CHUNK_NOISE) begin
            send_byte(value, $urandom_range(0, 3) == 0, produced);
         end else begin
            send_byte(value, k == len - 1, produced);
         end
      end
   endtask

   // nothing outstanding, plus a settling wait for bytes that cause no reply
   task automatic drain_replies();
      while (reply_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver: random stalls, one long hold-off on request, none in the tail
   initial begin
      rsp_if.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_request != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got_reply = reply_byte_type'{rsp_if.tx_byte, rsp_if.tx_final,
                                      rsp_if.link_ok_first, rsp_if.link_ok_second};
         if (reply_bytes_due.size() == 0) begin
            log_failure($sformatf("unexpected reply byte %02h final %b flags %b%b",
                                  got_reply.tx_byte, got_reply.tx_final,
                                  got_reply.link_first, got_reply.link_second));
         end else begin
            want_reply = reply_bytes_due.pop_front();
            replies_seen++;
            if (got_reply !== want_reply) begin
               log_failure($sformatf({"reply byte: expected %02h final %b flags %b%b, ",
                                      "got %02h final %b flags %b%b"},
                                     want_reply.tx_byte, want_reply.tx_final,
                                     want_reply.link_first, want_reply.link_second,
                                     got_reply.tx_byte, got_reply.tx_final,
                                     got_reply.link_first, got_reply.link_second));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reply bytes outstanding",
                  cycle_count, reply_bytes_due.size());
         $display("exception_reply_responder_test NOT OK");
         $finish;
      end
   end

   initial begin
      int          produced;
      int          phase;
      int          pick;
      int          budget;
      int          directed_enabled;
      logic [7:0]  wdata;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.rx_byte   <= '0;
      req_if.chunk_end <= 1'b0;
      csr_we           <= 1'b0;
      csr_index        <= CSR_SLAVE_ADDRESS;
      csr_wdata        <= '0;
      model_cfg   = '{slave_address: 8'h00, listen_on_second_port: 1'b1,
                      responder_enabled: 1'b0};
      chunk_bytes = '0;
      held_addr   = '0;
      held_func   = '0;
      link_first  = 1'b0;
      link_second = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int row = 0; row < $size(script); row++) begin
         if (script[row].kind == ROW_REG) begin
            req_if.valid <= 1'b0;
            drain_replies();
            write_reg(script[row].index, script[row].data);
         end else begin
            send_byte(script[row].data, script[row].last, produced);
            if (script[row].replies != ANY_COUNT &&
                (produced != script[row].replies ||
                 (produced == REPLY_LEN && last_func_byte != script[row].func))) begin
               log_failure($sformatf({"table row %0d: expected %0d reply bytes, ",
                                      "function %02h, got %0d, function %02h"},
                                     row, script[row].replies, script[row].func,
                                     produced, last_func_byte));
            end
         end
      end
      directed_enabled = bytes_enabled;

      phase = 0;
      while (bytes_enabled - directed_enabled < RANDOM_TARGET) begin
         req_if.valid <= 1'b0;
         drain_replies();
         quiet = (bytes_enabled - directed_enabled >= RANDOM_TARGET - QUIET_TAIL);
         pick = $urandom_range(0, 3);
         wdata = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
         if (phase == 0 || $urandom_range(0, 1) == 1) begin
            write_reg(CSR_SLAVE_ADDRESS, wdata);
         end
         if ($urandom_range(0, 1) == 1) begin
            write_reg(CSR_LISTEN_SECOND, 8'($urandom));
         end
         wdata = 8'($urandom);
         wdata[0] = (phase == HOLD_PHASE) || ($urandom_range(0, 7) != 0);
         write_reg(CSR_RESPONDER_ENABLED, wdata);
         // hold the receiver off while well-formed chunks keep coming
         if (phase == HOLD_PHASE) begin
            hold_request = LONG_HOLD;
         end

         budget = model_cfg.responder_enabled ? 36 : 8;
         phase_bytes = 0;
         while (phase_bytes < budget) begin
            pick = $urandom_range(0, 99);
            if (phase == HOLD_PHASE || pick < 70) begin
               send_chunk(CHUNK_GOOD);
            end else if (pick < 82) begin
               send_chunk(CHUNK_SHORT);
            end else if (pick < 92) begin
               send_chunk(CHUNK_FOREIGN);
            end else begin
               send_chunk(CHUNK_NOISE);
            end
         end
         // leave no chunk open across a register write
         if (!chunk_closed) begin
            send_byte(8'($urandom), 1'b1, produced);
         end
         phase++;
      end

      req_if.valid <= 1'b0;
      drain_replies();
      $display("sent %0d bytes (%0d while enabled) in %0d random phases, %0d register writes",
               bytes_sent, bytes_enabled, phase, reg_writes);
      $display("checked %0d reply bytes from %0d replies, one receiver hold-off of %0d cycles",
               replies_seen, replies_due, LONG_HOLD);
      if (fail_count == 0) begin
         $display("exception_reply_responder_test OK");
      end else begin
         $display("%0d failures", fail_count);
         $display("exception_reply_responder_test NOT OK");
      end
      $finish;
   end

endmodule
